/* rtl/rffp_pkg.sv */
// Shared constants and types for the ring flow field point core.
`default_nettype none
package rffp_pkg;

    localparam int GRID_WIDTH  = 1024;
    localparam int GRID_HEIGHT = 1024;

    localparam int COORD_W = 10;
    localparam int OFF_W   = 11;
    localparam int STEP_W  = 20;
    localparam int RAD_W   = 19;
    localparam int SCALE_W = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int R2_W    = 21;
    localparam int ROOT_W  = 27;
    localparam int MAG_W   = 54;
    localparam int DEN_W   = 27;
    localparam int FLOW_W  = 32;

    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = FLOW_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int TOT_LAT   = SQ_STEPS + DIV_LAT;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_INNER    = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUTER    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_UNIFORM  = 3'd5;

    localparam logic [FLOW_W-1:0] FLOW_MAX = 32'h7FFF_FFFF;
    localparam logic [FLOW_W-1:0] FLOW_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               ring;
        logic               neg_u;
        logic               neg_v;
    } side_t;

endpackage
`default_nettype wire

/* rtl/rffp_sqrt.sv */
// Pipelined digit-by-digit square root of r2 * 2^32, one result bit per stage.
`default_nettype none
module rffp_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [rffp_pkg::R2_W-1:0]   in_r2,
    output logic                             out_valid,
    output logic [rffp_pkg::ROOT_W-1:0]      out_root
);
    import rffp_pkg::*;

    localparam int XR_W  = R2_W + 1;
    localparam int REM_W = ROOT_W + 2;
    localparam int CUR_W = REM_W + 2;

    logic              valid_reg [SQ_STEPS];
    logic [REM_W-1:0]  rem_reg   [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg  [SQ_STEPS];
    logic [XR_W-1:0]   xr_reg    [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic              valid_src;
            logic [REM_W-1:0]  rem_src;
            logic [ROOT_W-1:0] root_src;
            logic [XR_W-1:0]   xr_src;
            logic [CUR_W-1:0]  cur;
            logic [CUR_W-1:0]  trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign valid_src = in_valid;
                assign rem_src   = '0;
                assign root_src  = '0;
                assign xr_src    = {1'b0, in_r2};
            end else begin : g_next
                assign valid_src = valid_reg[k-1];
                assign rem_src   = rem_reg[k-1];
                assign root_src  = root_reg[k-1];
                assign xr_src    = xr_reg[k-1];
            end

            assign cur   = {rem_src, xr_src[XR_W-1 -: 2]};
            assign trial = {2'b00, root_src, 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                root_reg[k] <= {root_src[ROOT_W-2:0], ge};
                xr_reg[k]   <= {xr_src[XR_W-3:0], 2'b00};
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];

endmodule
`default_nettype wire

/* rtl/rffp_div.sv */
// Pipelined rounded divide with saturation detect: an input stage, then one quotient bit per stage.
`default_nettype none
module rffp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [rffp_pkg::MAG_W-1:0]  in_mag,
    input  wire logic [rffp_pkg::DEN_W-1:0]  in_den,
    output logic                             out_valid,
    output logic [rffp_pkg::FLOW_W-1:0]      out_q,
    output logic                             out_sat,
    output logic                             out_den_zero
);
    import rffp_pkg::*;

    localparam int HI_W  = MAG_W - FLOW_W;
    localparam int CUR_W = DEN_W + 1;

    logic [MAG_W-1:0] madd;
    logic             sat_in;

    logic              valid_reg [DIV_LAT];
    logic [DEN_W-1:0]  rem_reg   [DIV_LAT];
    logic [FLOW_W-1:0] low_reg   [DIV_LAT];
    logic [FLOW_W-1:0] q_reg     [DIV_LAT];
    logic [DEN_W-1:0]  den_reg   [DIV_LAT];
    logic              sat_reg   [DIV_LAT];

    // round half away from zero: add den/2 before truncating divide
    assign madd   = in_mag + MAG_W'(in_den >> 1);
    assign sat_in = ({{(DEN_W-HI_W){1'b0}}, madd[MAG_W-1:FLOW_W]} >= in_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(DEN_W-HI_W){1'b0}}, madd[MAG_W-1:FLOW_W]};
        low_reg[0] <= madd[FLOW_W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= in_den;
        sat_reg[0] <= sat_in;
    end

    genvar k;
    generate
        for (k = 1; k < DIV_LAT; k++) begin : g_step
            logic [CUR_W-1:0] cur;
            logic             ge;

            assign cur = {rem_reg[k-1], low_reg[k-1][FLOW_W-1]};
            assign ge  = (cur >= {1'b0, den_reg[k-1]});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? DEN_W'(cur - {1'b0, den_reg[k-1]}) : DEN_W'(cur);
                low_reg[k] <= {low_reg[k-1][FLOW_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][FLOW_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    endgenerate

    assign out_valid    = valid_reg[DIV_LAT-1];
    assign out_q        = q_reg[DIV_LAT-1];
    assign out_sat      = sat_reg[DIV_LAT-1];
    assign out_den_zero = (den_reg[DIV_LAT-1] == '0);

endmodule
`default_nettype wire

/* rtl/ring_flow_field_point_core.sv */
// Ring flow field point core: tangential flow for one grid point per cycle.
// A request is taken on every cycle that start is high (busy stays low), and
// its result appears with done after 4 setup stages, a 27-stage square root
// (one root bit per stage), a 33-stage rounding divide (an input stage, then
// one quotient bit per stage) and an output register. Results cannot be
// held off; done is a one-cycle strobe. Write configuration only while no
// request is in flight.
`default_nettype none
module ring_flow_field_point_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rffp_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [rffp_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rffp_pkg::COORD_W-1:0]  col_index,
    input  wire logic [rffp_pkg::COORD_W-1:0]  row_index,
    input  wire logic [rffp_pkg::STEP_W-1:0]   step_x,
    input  wire logic [rffp_pkg::STEP_W-1:0]   step_y,
    output logic                               done,
    output logic                               in_ring,
    output logic signed [rffp_pkg::FLOW_W-1:0] flow_u,
    output logic signed [rffp_pkg::FLOW_W-1:0] flow_v,
    output logic [rffp_pkg::COORD_W-1:0]       out_col,
    output logic [rffp_pkg::COORD_W-1:0]       out_row
);
    import rffp_pkg::*;

    localparam int SQ_W   = 2 * RAD_W;
    localparam int PS_W   = OFF_W + STEP_W + 1;
    localparam int PROD_W = PS_W + SCALE_W;

    // configuration
    logic [COORD_W-1:0]        center_x_reg;
    logic [COORD_W-1:0]        center_y_reg;
    logic [RAD_W-1:0]          inner_reg;
    logic [RAD_W-1:0]          outer_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                      uniform_reg;
    logic [SQ_W-1:0]           inner_sq_reg;
    logic [SQ_W-1:0]           outer_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= COORD_W'(512);
            center_y_reg <= COORD_W'(512);
            inner_reg    <= '0;
            outer_reg    <= '1;
            scale_reg    <= SCALE_W'(65536);
            uniform_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[COORD_W-1:0];
                REG_INNER:    inner_reg    <= cfg_data[RAD_W-1:0];
                REG_OUTER:    outer_reg    <= cfg_data[RAD_W-1:0];
                REG_SCALE:    scale_reg    <= $signed(cfg_data[SCALE_W-1:0]);
                REG_UNIFORM:  uniform_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        inner_sq_reg <= inner_reg * inner_reg;
        outer_sq_reg <= outer_reg * outer_reg;
    end

    assign busy = 1'b0;

    // stage 1: offsets
    logic                      v1_reg;
    logic [COORD_W-1:0]        col1_reg, row1_reg;
    logic [STEP_W-1:0]         sx1_reg, sy1_reg;
    logic signed [OFF_W-1:0]   ox1_reg, oy1_reg;

    // stage 2: squares and first products
    logic                      v2_reg;
    logic [COORD_W-1:0]        col2_reg, row2_reg;
    logic                      grid2_reg;
    logic [R2_W-2:0]           oxx2_reg, oyy2_reg;
    logic signed [PS_W-1:0]    pu2_reg, pv2_reg;
    logic signed [2*OFF_W-1:0] oxx_full, oyy_full;
    logic signed [PS_W-1:0]    pu_full, pv_full;

    // stage 3: radius squared and full numerators
    logic                      v3_reg;
    logic [COORD_W-1:0]        col3_reg, row3_reg;
    logic                      grid3_reg;
    logic [R2_W-1:0]           r2_3_reg;
    logic signed [PROD_W-1:0]  pu3_reg, pv3_reg;
    logic signed [PROD_W-1:0]  pu_prod, pv_prod;

    // stage 4: ring test and magnitudes
    logic                      v4_reg;
    logic [R2_W-1:0]           r2_4_reg;
    side_t                     side4_reg;
    logic [MAG_W-1:0]          magu4_reg, magv4_reg;
    logic [SQ_W-1:0]           r2s;
    logic signed [PROD_W-1:0]  absu, absv;

    assign oxx_full = ox1_reg * ox1_reg;
    assign oyy_full = oy1_reg * oy1_reg;
    assign pu_full  = oy1_reg * $signed({1'b0, sx1_reg});
    assign pv_full  = ox1_reg * $signed({1'b0, sy1_reg});
    assign pu_prod  = pu2_reg * scale_reg;
    assign pv_prod  = pv2_reg * scale_reg;
    assign r2s      = {{(SQ_W-R2_W-16){1'b0}}, r2_3_reg, 16'h0000};
    assign absu     = (pu3_reg < 0) ? -pu3_reg : pu3_reg;
    assign absv     = (pv3_reg < 0) ? -pv3_reg : pv3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col1_reg <= col_index;
        row1_reg <= row_index;
        sx1_reg  <= step_x;
        sy1_reg  <= step_y;
        ox1_reg  <= $signed({1'b0, col_index}) - $signed({1'b0, center_x_reg});
        oy1_reg  <= $signed({1'b0, row_index}) - $signed({1'b0, center_y_reg});

        col2_reg  <= col1_reg;
        row2_reg  <= row1_reg;
        grid2_reg <= ({1'b0, col1_reg} < OFF_W'(GRID_WIDTH))
                  && ({1'b0, row1_reg} < OFF_W'(GRID_HEIGHT));
        oxx2_reg  <= oxx_full[R2_W-2:0];
        oyy2_reg  <= oyy_full[R2_W-2:0];
        pu2_reg   <= pu_full;
        pv2_reg   <= pv_full;

        col3_reg  <= col2_reg;
        row3_reg  <= row2_reg;
        grid3_reg <= grid2_reg;
        r2_3_reg  <= {1'b0, oxx2_reg} + {1'b0, oyy2_reg};
        pu3_reg   <= pu_prod;
        pv3_reg   <= pv_prod;

        r2_4_reg        <= r2_3_reg;
        side4_reg.col   <= col3_reg;
        side4_reg.row   <= row3_reg;
        side4_reg.ring  <= grid3_reg && (r2s >= inner_sq_reg) && (r2s <= outer_sq_reg);
        side4_reg.neg_u <= (pu3_reg > 0);
        side4_reg.neg_v <= (pv3_reg < 0);
        magu4_reg       <= absu[MAG_W-1:0];
        magv4_reg       <= absv[MAG_W-1:0];
    end

    // square root
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;

    rffp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_r2     (r2_4_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    // side data and numerators ride alongside
    side_t            side_reg [TOT_LAT];
    logic [MAG_W-1:0] magu_reg [SQ_STEPS];
    logic [MAG_W-1:0] magv_reg [SQ_STEPS];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side4_reg;
        magu_reg[0] <= magu4_reg;
        magv_reg[0] <= magv4_reg;
        for (int i = 1; i < TOT_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        for (int i = 1; i < SQ_STEPS; i++)
        begin
            magu_reg[i] <= magu_reg[i-1];
            magv_reg[i] <= magv_reg[i-1];
        end
    end

    logic [DEN_W-1:0] den;
    assign den = uniform_reg ? sq_root : {inner_reg, 8'h00};

    logic              du_valid, dv_valid;
    logic [FLOW_W-1:0] du_q, dv_q;
    logic              du_sat, dv_sat;
    logic              du_zero, dv_zero;

    rffp_div u_div_u (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sq_valid),
        .in_mag       (magu_reg[SQ_STEPS-1]),
        .in_den       (den),
        .out_valid    (du_valid),
        .out_q        (du_q),
        .out_sat      (du_sat),
        .out_den_zero (du_zero)
    );

    rffp_div u_div_v (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sq_valid),
        .in_mag       (magv_reg[SQ_STEPS-1]),
        .in_den       (den),
        .out_valid    (dv_valid),
        .out_q        (dv_q),
        .out_sat      (dv_sat),
        .out_den_zero (dv_zero)
    );

    function automatic logic [FLOW_W-1:0] sat_flow(
        input logic              keep,
        input logic              neg,
        input logic              sat,
        input logic [FLOW_W-1:0] q
    );
        logic big;
        big = sat || q[FLOW_W-1];
        if (!keep)
            return '0;
        else if (neg)
            return big ? FLOW_MIN : FLOW_W'('0 - q);
        else
            return big ? FLOW_MAX : q;
    endfunction

    side_t side_out;
    assign side_out = side_reg[TOT_LAT-1];

    logic              done_reg;
    logic              in_ring_reg;
    logic [FLOW_W-1:0] flow_u_reg, flow_v_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= du_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_ring_reg <= side_out.ring;
        flow_u_reg  <= sat_flow(side_out.ring && !du_zero, side_out.neg_u, du_sat, du_q);
        flow_v_reg  <= sat_flow(side_out.ring && !dv_zero, side_out.neg_v, dv_sat, dv_q);
        out_col_reg <= side_out.col;
        out_row_reg <= side_out.row;
    end

    assign done    = done_reg;
    assign in_ring = in_ring_reg;
    assign flow_u  = $signed(flow_u_reg);
    assign flow_v  = $signed(flow_v_reg);
    assign out_col = out_col_reg;
    assign out_row = out_row_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        du_valid == dv_valid)
        else $error("divider lanes out of step");

    a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> $past(v4_reg, SQ_STEPS))
        else $error("root without request");

    a_out_ring_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_ring) |-> (flow_u == 0 && flow_v == 0))
        else $error("flow outside ring");

    a_done_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(du_valid))
        else $error("done without divider result");

endmodule
`default_nettype wire
